// ===== rtl/qrc_pkg.sv =====
// qrc_pkg: shared types and constants for the jpeg quality rate control block
// holds item structs, register map and q bounds; no dependencies
`timescale 1ns / 1ps

package qrc_pkg;

    // field widths
    localparam int unsigned QW     = 7;
    localparam int unsigned SIZEW  = 24;
    localparam int unsigned ADDRW  = 4;
    localparam int unsigned DATAW  = 32;

    // signed working width for q arithmetic and size thresholds
    localparam int unsigned QSW    = 9;
    localparam int unsigned THW    = SIZEW + 2;

    // opcodes
    localparam logic OP_REPORT = 1'b0;
    localparam logic OP_LOAD   = 1'b1;

    // register map, word index
    typedef enum logic [1:0] {
        REG_SIZE_LIMIT  = 2'd0,
        REG_LARGE_MODE  = 2'd1,
        REG_START_LUMA  = 2'd2,
        REG_START_CHROMA = 2'd3
    } qrc_reg_t;

    // reset values
    localparam logic [SIZEW-1:0] SIZE_LIMIT_RST   = 24'd262144;
    localparam logic [QW-1:0]    START_LUMA_RST   = 7'd50;
    localparam logic [QW-1:0]    START_CHROMA_RST = 7'd40;

    // step sizes and thresholds
    localparam logic signed [QSW-1:0] Y_STEP   = 9'sd5;
    localparam logic signed [QSW-1:0] UV_STEP  = 9'sd10;
    localparam logic signed [QSW-1:0] Q_GAP    = 9'sd15;
    localparam logic signed [THW-1:0] HI_MARGIN = 26'sd30720;
    localparam logic signed [THW-1:0] LO_MARGIN = 26'sd61440;

    // clamp bounds, large-frame mode
    localparam logic signed [QSW-1:0] Y_MIN_L  = 9'sd30;
    localparam logic signed [QSW-1:0] Y_MAX_L  = 9'sd60;
    localparam logic signed [QSW-1:0] UV_MIN_L = 9'sd30;
    localparam logic signed [QSW-1:0] UV_MAX_L = 9'sd45;
    // clamp bounds, small-frame mode
    localparam logic signed [QSW-1:0] Y_MIN_S  = 9'sd35;
    localparam logic signed [QSW-1:0] Y_MAX_S  = 9'sd70;
    localparam logic signed [QSW-1:0] UV_MIN_S = 9'sd30;
    localparam logic signed [QSW-1:0] UV_MAX_S = 9'sd55;

    typedef struct packed {
        logic             opcode;
        logic [SIZEW-1:0] frame_size;
        logic             buffer_full;
    } qrc_in_t;

    typedef struct packed {
        logic [QW-1:0] luma_q;
        logic [QW-1:0] chroma_q;
    } qrc_out_t;

    typedef struct packed {
        logic [SIZEW-1:0] size_limit;
        logic             large_frame_mode;
        logic [QW-1:0]    start_luma_q;
        logic [QW-1:0]    start_chroma_q;
    } qrc_cfg_t;

endpackage

// ===== rtl/qrc_cfg_regs.sv =====
// qrc_cfg_regs: apb register file for the quality rate control settings
// depends on qrc_pkg
`timescale 1ns / 1ps

module qrc_cfg_regs (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [qrc_pkg::ADDRW-1:0]   paddr,
    input  logic [qrc_pkg::DATAW-1:0]   pwdata,
    output logic [qrc_pkg::DATAW-1:0]   prdata,
    output logic                        pready,
    output qrc_pkg::qrc_cfg_t           cfg
);
    import qrc_pkg::*;

    qrc_cfg_t cfg_reg;
    qrc_reg_t sel;
    logic     wr_en;

    assign sel    = qrc_reg_t'(paddr[ADDRW-1:2]);
    assign wr_en  = psel & penable & pwrite;
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    // register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.size_limit       <= SIZE_LIMIT_RST;
            cfg_reg.large_frame_mode <= 1'b0;
            cfg_reg.start_luma_q     <= START_LUMA_RST;
            cfg_reg.start_chroma_q   <= START_CHROMA_RST;
        end
        else if (wr_en)
        begin
            unique case (sel)
                REG_SIZE_LIMIT:   cfg_reg.size_limit       <= pwdata[SIZEW-1:0];
                REG_LARGE_MODE:   cfg_reg.large_frame_mode <= pwdata[0];
                REG_START_LUMA:   cfg_reg.start_luma_q     <= pwdata[QW-1:0];
                REG_START_CHROMA: cfg_reg.start_chroma_q   <= pwdata[QW-1:0];
            endcase
        end
    end

    // read mux
    always_comb
    begin
        prdata = '0;
        unique case (sel)
            REG_SIZE_LIMIT:   prdata[SIZEW-1:0] = cfg_reg.size_limit;
            REG_LARGE_MODE:   prdata[0]         = cfg_reg.large_frame_mode;
            REG_START_LUMA:   prdata[QW-1:0]    = cfg_reg.start_luma_q;
            REG_START_CHROMA: prdata[QW-1:0]    = cfg_reg.start_chroma_q;
        endcase
    end

endmodule

// ===== rtl/qrc_update.sv =====
// qrc_update: next luma/chroma q from the current q, one item and the settings
// combinational; depends on qrc_pkg
`timescale 1ns / 1ps

module qrc_update (
    input  qrc_pkg::qrc_cfg_t         cfg,
    input  qrc_pkg::qrc_in_t          item,
    input  logic [qrc_pkg::QW-1:0]    luma_q_now,
    input  logic [qrc_pkg::QW-1:0]    chroma_q_now,
    output qrc_pkg::qrc_out_t         result
);
    import qrc_pkg::*;

    logic signed [QSW-1:0] y_cur;
    logic signed [QSW-1:0] uv_cur;
    logic signed [QSW-1:0] y_adj;
    logic signed [QSW-1:0] uv_adj;
    logic signed [QSW-1:0] y_lo;
    logic signed [QSW-1:0] y_hi;
    logic signed [QSW-1:0] uv_lo;
    logic signed [QSW-1:0] uv_hi;
    logic signed [QSW-1:0] y_clamp;
    logic signed [QSW-1:0] uv_clamp;
    logic signed [THW-1:0] limit_s;
    logic signed [THW-1:0] fsize_s;
    logic signed [THW-1:0] hi_th;
    logic signed [THW-1:0] lo_th;
    logic                  wide_gap;
    logic                  too_big;
    logic                  too_small;

    // signed views of the current state and the size thresholds
    assign y_cur    = signed'({{(QSW-QW){1'b0}}, luma_q_now});
    assign uv_cur   = signed'({{(QSW-QW){1'b0}}, chroma_q_now});
    assign limit_s  = signed'({{(THW-SIZEW){1'b0}}, cfg.size_limit});
    assign fsize_s  = signed'({{(THW-SIZEW){1'b0}}, item.frame_size});
    assign hi_th    = limit_s - HI_MARGIN;
    assign lo_th    = limit_s - LO_MARGIN;
    assign wide_gap = (y_cur - uv_cur) >= Q_GAP;
    assign too_big  = fsize_s > hi_th;
    assign too_small = fsize_s < lo_th;

    // one step on a report
    always_comb
    begin
        y_adj  = y_cur;
        uv_adj = uv_cur;
        priority if (item.buffer_full)
        begin
            y_adj  = y_cur - Q_GAP;
            uv_adj = uv_cur - Q_GAP;
        end
        else if (too_big)
        begin
            if (wide_gap)
                y_adj = y_cur - Y_STEP;
            else
                uv_adj = uv_cur - UV_STEP;
        end
        else if (too_small)
        begin
            if (wide_gap)
                uv_adj = uv_cur + UV_STEP;
            else
                y_adj = y_cur + Y_STEP;
        end
        else
        begin
            // size between the thresholds, no step
            y_adj  = y_cur;
            uv_adj = uv_cur;
        end
    end

    // mode bounds
    assign y_lo  = cfg.large_frame_mode ? Y_MIN_L  : Y_MIN_S;
    assign y_hi  = cfg.large_frame_mode ? Y_MAX_L  : Y_MAX_S;
    assign uv_lo = cfg.large_frame_mode ? UV_MIN_L : UV_MIN_S;
    assign uv_hi = cfg.large_frame_mode ? UV_MAX_L : UV_MAX_S;

    // clamp
    assign y_clamp  = (y_adj < y_lo) ? y_lo : ((y_adj > y_hi) ? y_hi : y_adj);
    assign uv_clamp = (uv_adj < uv_lo) ? uv_lo : ((uv_adj > uv_hi) ? uv_hi : uv_adj);

    // load takes the start values unclamped
    always_comb
    begin
        if (item.opcode == OP_LOAD)
        begin
            result.luma_q   = cfg.start_luma_q;
            result.chroma_q = cfg.start_chroma_q;
        end
        else
        begin
            result.luma_q   = y_clamp[QW-1:0];
            result.chroma_q = uv_clamp[QW-1:0];
        end
    end

endmodule

// ===== rtl/jpeg_quality_rate_control_core.sv =====
// jpeg_quality_rate_control_core: an accepted item passes from the input register
// through one update step into the result register, which shows it from then on.
// throughput one item per cycle while out_stall is low; else in_stall holds it.
// the luma/chroma q state updates as an item leaves the input register.
// reset: pipeline empty, q state 50/40, registers to their reset values.
// depends on qrc_pkg, qrc_cfg_regs, qrc_update
`timescale 1ns / 1ps

module jpeg_quality_rate_control_core (
    input  logic                        clk,
    input  logic                        rst_n,
    // item input
    input  logic                        in_valid,
    output logic                        in_stall,
    input  qrc_pkg::qrc_in_t            in_item,
    // result output
    output logic                        out_valid,
    input  logic                        out_stall,
    output qrc_pkg::qrc_out_t           out_item,
    // configuration
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [qrc_pkg::ADDRW-1:0]   paddr,
    input  logic [qrc_pkg::DATAW-1:0]   pwdata,
    output logic [qrc_pkg::DATAW-1:0]   prdata,
    output logic                        pready
);
    import qrc_pkg::*;

    qrc_cfg_t      cfg;
    qrc_in_t       in_item_reg;
    logic          in_valid_reg;
    qrc_out_t      out_item_reg;
    logic          out_valid_reg;
    qrc_out_t      upd_result;
    logic [QW-1:0] luma_q_now_reg;
    logic [QW-1:0] chroma_q_now_reg;
    logic          out_free;
    logic          advance;
    logic          in_take;

    qrc_cfg_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    qrc_update u_update (
        .cfg          (cfg),
        .item         (in_item_reg),
        .luma_q_now   (luma_q_now_reg),
        .chroma_q_now (chroma_q_now_reg),
        .result       (upd_result)
    );

    // handshake
    assign out_free  = !out_valid_reg || !out_stall;
    assign advance   = in_valid_reg && out_free;
    assign in_stall  = in_valid_reg && !out_free;
    assign in_take   = in_valid && !in_stall;
    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

    // input register control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (!in_stall)
            in_valid_reg <= in_valid;
    end

    // input register payload
    always_ff @(posedge clk)
    begin
        if (in_take)
            in_item_reg <= in_item;
    end

    // q state and result valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            luma_q_now_reg   <= START_LUMA_RST;
            chroma_q_now_reg <= START_CHROMA_RST;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            if (advance)
            begin
                luma_q_now_reg   <= upd_result.luma_q;
                chroma_q_now_reg <= upd_result.chroma_q;
            end
            if (out_free)
                out_valid_reg <= in_valid_reg;
        end
    end

    // result register payload
    always_ff @(posedge clk)
    begin
        if (advance)
            out_item_reg <= upd_result;
    end

endmodule
